FILE: src/rrir_pkg.sv
// Package for the RR interval uniform resampler.
// Holds the shared widths, constants, the queued job type and the sequencer states.
// No dependencies.
package rrir_pkg;

    // Field and datapath widths.
    localparam int INTERVAL_W = 12;
    localparam int RATE_W     = 4;
    localparam int SPAN_W     = 15;
    localparam int TIME_W     = 32;
    localparam int VALUE_W    = 20;
    localparam int NUM_W      = INTERVAL_W + SPAN_W;

    // Timing constants, in scaled time units of 1/(1000*rate) s, and the cap on samples per beat.
    localparam int unsigned SAMPLE_STEP = 1000;
    localparam int unsigned MAX_RESULTS = 33;
    localparam int COUNT_W = $clog2(MAX_RESULTS + 1);

    // Rate register limits and reset value.
    localparam int unsigned RATE_RESET = 4;
    localparam int unsigned RATE_MAX   = 8;

    // Defaults for the top-level parameters.
    localparam int FRACTION_BITS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF   = 2;

    // One classified beat as it travels from the front end to the back end.
    typedef struct packed {
        logic [INTERVAL_W-1:0] cur;
        logic [SPAN_W-1:0]     span;
        logic                  last;
    } rrir_job_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_WAIT,
        ST_EMIT,
         ST_COMMIT
    } rrir_state_t;

endpackage

FILE: src/rr_interval_uniform_resampler_top.sv
// Top level of the RR interval uniform resampler.
// Connects the front end, job queue, back-end sequencer and serial divider.
// Depends on rrir_pkg, rrir_front, rrir_fifo, rrir_div and rrir_back.
//
// Usage:
//   Beats enter on the beat channel (beat_valid, beat_stall, rr_interval_ms, record_end).
//   A transaction is taken at a rising edge with beat_valid high and beat_stall low.
//   Resampled values leave on the sample channel (sample_valid, sample_stall,
//   sample_value, last_in_run); last_in_run marks the final sample caused by a beat.
//   The user writes the rate register (cfg_we, cfg_wdata) only while idle; not enforced.
// Timing:
//   The front end classifies a beat in the cycle it is taken and queues it, so beats
//   are accepted until the queue of QUEUE_DEPTH entries fills.
//   The back end takes a beat from the queue, runs CHECK, MUL1, MUL2, DIV, WAIT and EMIT
//   for each sample and closes the beat in COMMIT; the serial divider, one quotient bit
//   per cycle, sets the sample rate.
// Reset and stall:
//   Reset clears the queue, beat and sample times and sets the rate to 4 Hz.
//   A stalled sample holds in the output register; the back end computes the next
//   sample meanwhile and waits only when it needs the output register.
module rr_interval_uniform_resampler_top #(
    parameter int FRACTION_BITS = rrir_pkg::FRACTION_BITS_DEF,
    parameter int QUEUE_DEPTH   = rrir_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rrir_pkg::RATE_W-1:0]         cfg_wdata,
    input  logic                                beat_valid,
    output logic                                beat_stall,
    input  logic [rrir_pkg::INTERVAL_W-1:0]     rr_interval_ms,
    input  logic                                record_end,
    output logic                                sample_valid,
    input  logic                                sample_stall,
    output logic [rrir_pkg::VALUE_W-1:0]        sample_value,
    output logic                                last_in_run
);
    import rrir_pkg::*;

    localparam int QW = INTERVAL_W + FRACTION_BITS;

    rrir_job_t          push_job;
    rrir_job_t          head_job;
    logic               push;
    logic               pop;
    logic               queue_full;
    logic               queue_empty;
    logic               div_start;
    logic               div_busy;
    logic               div_done;
    logic [NUM_W-1:0]   div_num;
    logic [SPAN_W-1:0]  div_den;
    logic [QW-1:0]      div_quot;

    // Front end: rate register and beat classification.
    rrir_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .beat_valid     (beat_valid),
        .beat_stall     (beat_stall),
        .rr_interval_ms (rr_interval_ms),
        .record_end     (record_end),
        .queue_full     (queue_full),
        .push           (push),
        .job            (push_job)
    );

    // Job queue between the two halves.
    rrir_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    // Serial divider shared by all samples.
    rrir_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Back end: sample sequencer and output register.
    rrir_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_job     (head_job),
        .queue_empty  (queue_empty),
        .pop          (pop),
        .div_start    (div_start),
        .div_num      (div_num),
        .div_den      (div_den),
        .div_busy     (div_busy),
        .div_done     (div_done),
        .div_quot     (div_quot),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_value (sample_value),
        .last_in_run  (last_in_run)
    );

endmodule

FILE: src/rrir_front.sv
// Front end of the RR interval resampler: rate register and beat classification.
// Normalizes the interval, computes the scaled span and pushes a job into the queue.
// Depends on rrir_pkg.
module rrir_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rrir_pkg::RATE_W-1:0]         cfg_wdata,
    input  logic                                beat_valid,
    output logic                                beat_stall,
    input  logic [rrir_pkg::INTERVAL_W-1:0]     rr_interval_ms,
    input  logic                                record_end,
    input  logic                                queue_full,
    output logic                                push,
    output rrir_pkg::rrir_job_t                 job
);
    import rrir_pkg::*;

    localparam logic [RATE_W-1:0] RATE_ONE   = RATE_W'(1);
    localparam logic [RATE_W-1:0] RATE_LIMIT = RATE_W'(RATE_MAX);
    localparam logic [RATE_W-1:0] RATE_INIT  = RATE_W'(RATE_RESET);

    logic [RATE_W-1:0]     rate_reg;
    logic [RATE_W-1:0]     rate_next;
    logic [INTERVAL_W-1:0] cur;

    // Clamp written rates into the supported range.
    always_comb
    begin
        rate_next = rate_reg;
        if (cfg_we)
        begin
            if (cfg_wdata == '0)
            begin
                rate_next = RATE_ONE;
            end
            else if (cfg_wdata > RATE_LIMIT)
            begin
                rate_next = RATE_LIMIT;
            end
            else
            begin
                rate_next = cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= RATE_INIT;
        end
        else
        begin
            rate_reg <= rate_next;
        end
    end

    // A zero interval counts as one millisecond.
    assign cur = (rr_interval_ms == '0) ? INTERVAL_W'(1) : rr_interval_ms;

    // Classify the beat: the span is the interval in scaled time units.
    assign job.cur  = cur;
    assign job.span = SPAN_W'(cur) * SPAN_W'(rate_reg);
    assign job.last = record_end;

    // A transaction is taken whenever the queue has room.
    assign beat_stall = queue_full;
    assign push       = beat_valid && !queue_full;

endmodule

FILE: src/rrir_fifo.sv
// Short job queue between the front end and the back end of the resampler.
// Entries are kept in a small array with separate read and write pointers.
// Depends on rrir_pkg.
module rrir_fifo #(
    parameter int DEPTH = rrir_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rrir_pkg::rrir_job_t  push_job,
    input  logic                 pop,
    output rrir_pkg::rrir_job_t  head_job,
    output logic                 full,
    output logic                 empty
);
    import rrir_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    rrir_job_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign head_job = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    // The front end never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("rrir_fifo: push while full");

    // The back end never pops an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("rrir_fifo: pop while empty");

    // The fill count stays within the depth.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_FULL)
        else $error("rrir_fifo: fill count out of range");

endmodule

FILE: src/rrir_div.sv
// Serial restoring divider for the resampler back end, one quotient bit per cycle.
// Divides the interpolation numerator, scaled by the fraction bits, by the beat span.
// Depends on rrir_pkg.
module rrir_div #(
    parameter int FRACTION_BITS = rrir_pkg::FRACTION_BITS_DEF
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              start,
    input  logic [rrir_pkg::NUM_W-1:0]                        num,
    input  logic [rrir_pkg::SPAN_W-1:0]                       den,
    output logic                                              busy,
    output logic                                              done,
    output logic [rrir_pkg::INTERVAL_W+FRACTION_BITS-1:0]     quot
);
    import rrir_pkg::*;

    // The quotient is below 2^(INTERVAL_W+FRACTION_BITS) since num < span * 2^INTERVAL_W.
    localparam int QW    = INTERVAL_W + FRACTION_BITS;
    localparam int CNT_W = $clog2(QW + 1);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [SPAN_W-1:0] rem_reg;
    logic [SPAN_W-1:0] rem_next;
    logic [QW-1:0]    shf_reg;
    logic [QW-1:0]    shf_next;
    logic [SPAN_W:0]  trial;
    logic [SPAN_W:0]  diff;
    logic             ge;

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign trial = {rem_reg, shf_reg[QW-1]};
    assign diff  = trial - {1'b0, den};
    assign ge    = (trial >= {1'b0, den});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QW);
            rem_next  = num[NUM_W-1:INTERVAL_W];
            shf_next  = {num[INTERVAL_W-1:0], {FRACTION_BITS{1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
            shf_next = {shf_reg[QW-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shf_reg <= shf_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = shf_reg;

endmodule

FILE: src/rrir_back.sv
// Back end of the RR interval resampler: the per-beat sample sequencer.
// Keeps beat and sample times, interpolates each sample and drives the output register.
// Depends on rrir_pkg; uses rrir_div through ports.
module rrir_back #(
    parameter int FRACTION_BITS = rrir_pkg::FRACTION_BITS_DEF
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  rrir_pkg::rrir_job_t                               head_job,
    input  logic                                              queue_empty,
    output logic                                              pop,
    output logic                                              div_start,
    output logic [rrir_pkg::NUM_W-1:0]                        div_num,
    output logic [rrir_pkg::SPAN_W-1:0]                       div_den,
    input  logic                                              div_busy,
    input  logic                                              div_done,
    input  logic [rrir_pkg::INTERVAL_W+FRACTION_BITS-1:0]     div_quot,
    output logic                                              sample_valid,
    input  logic                                              sample_stall,
    output logic [rrir_pkg::VALUE_W-1:0]                      sample_value,
    output logic                                              last_in_run
);
    import rrir_pkg::*;

    localparam int QW    = INTERVAL_W + FRACTION_BITS;
    localparam int EXT_W = SPAN_W + 2;
    localparam logic [EXT_W-1:0]   STEP_X    = EXT_W'(SAMPLE_STEP);
    localparam logic [EXT_W-1:0]   STEP2_X   = EXT_W'(2 * SAMPLE_STEP);
    localparam logic [TIME_W-1:0]  STEP_T    = TIME_W'(SAMPLE_STEP);
    localparam logic [TIME_W:0]    STEP_W    = (TIME_W + 1)'(SAMPLE_STEP);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_RESULTS);
    localparam logic [COUNT_W-1:0] COUNT_PRE = COUNT_W'(MAX_RESULTS - 1);

    // Control state.
    rrir_state_t        state_reg;
    rrir_state_t        state_next;
    logic [TIME_W-1:0]  beat_time_reg;
    logic [TIME_W-1:0]  beat_time_next;
    logic [TIME_W-1:0]  next_time_reg;
    logic [TIME_W-1:0]  next_time_next;
    logic [INTERVAL_W-1:0] prev_reg;
    logic [INTERVAL_W-1:0] prev_next;
    logic               first_seen_reg;
    logic               first_seen_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    // Working registers for the beat and sample in progress.
    logic [INTERVAL_W-1:0] cur_reg;
    logic [INTERVAL_W-1:0] cur_next;
    logic [SPAN_W-1:0]     span_reg;
    logic [SPAN_W-1:0]     span_next;
    logic                  last_reg;
    logic                  last_next;
    logic [INTERVAL_W-1:0] prev_use_reg;
    logic [INTERVAL_W-1:0] prev_use_next;
    logic [SPAN_W-1:0]     dt_reg;
    logic [SPAN_W-1:0]     dt_next;
    logic [NUM_W-1:0]      prod_reg;
    logic [NUM_W-1:0]      prod_next;
    logic [NUM_W-1:0]      num_reg;
    logic [NUM_W-1:0]      num_next;
    logic                  final_reg;
    logic                  final_next;
    logic [VALUE_W-1:0]    out_value_reg;
    logic [VALUE_W-1:0]    out_value_next;
    logic                  out_last_reg;
    logic                  out_last_next;

    // Datapath terms.
    logic [TIME_W-1:0]       dt_full;
    logic [TIME_W:0]         dt_plus_step;
    logic                    stop;
    logic [EXT_W-1:0]        dt_step1;
    logic [EXT_W-1:0]        dt_step2;
    logic [NUM_W-1:0]        prod_a;
    logic [NUM_W-1:0]        prod_b;
    logic [QW+VALUE_W-1:0]   quot_ext;
    logic [VALUE_W-1:0]      value_sat;
    logic                    out_free;

    // Offset of the next sample past the previous beat, and the stop test.
    assign dt_full      = next_time_reg - beat_time_reg;
    assign dt_plus_step = {1'b0, dt_full} + STEP_W;
    assign stop = (dt_full > TIME_W'(span_reg))
               || (last_reg && (dt_plus_step > (TIME_W + 1)'(span_reg)))
               || (count_reg == COUNT_MAX);

    // A sample is the last of its beat when the following one would stop.
    assign dt_step1 = EXT_W'(dt_reg) + STEP_X;
    assign dt_step2 = EXT_W'(dt_reg) + STEP2_X;

    // Interpolation numerator, one product per cycle.
    assign prod_a = NUM_W'(prev_use_reg) * NUM_W'(span_reg - dt_reg);
    assign prod_b = NUM_W'(cur_reg) * NUM_W'(dt_reg);

    // Saturate the quotient to the output width.
    assign quot_ext  = {{VALUE_W{1'b0}}, div_quot};
    assign value_sat = (|quot_ext[QW+VALUE_W-1:VALUE_W]) ? '1 : quot_ext[VALUE_W-1:0];

    assign out_free = !out_valid_reg || !sample_stall;

    // Sequencer: next state and datapath updates.
    always_comb
    begin
        state_next      = state_reg;
        beat_time_next  = beat_time_reg;
        next_time_next  = next_time_reg;
        prev_next       = prev_reg;
        first_seen_next = first_seen_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && sample_stall;
        cur_next        = cur_reg;
        span_next       = span_reg;
        last_next       = last_reg;
        prev_use_next   = prev_use_reg;
        dt_next         = dt_reg;
        prod_next       = prod_reg;
        num_next        = num_reg;
        final_next      = final_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        pop             = 1'b0;
        div_start       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop           = 1'b1;
                    cur_next      = head_job.cur;
                    span_next     = head_job.span;
                    last_next     = head_job.last;
                    prev_use_next = first_seen_reg ? prev_reg : head_job.cur;
                    count_next    = '0;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                dt_next = dt_full[SPAN_W-1:0];
                if (stop)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                prod_next  = prod_a;
                final_next = (dt_step1 > EXT_W'(span_reg))
                          || (last_reg && (dt_step2 > EXT_W'(span_reg)))
                          || (count_reg == COUNT_PRE);
                next_time_next = next_time_reg + STEP_T;
                count_next     = count_reg + COUNT_W'(1);
                state_next     = ST_MUL2;
            end
            ST_MUL2:
            begin
                num_next   = prod_reg + prod_b;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = value_sat;
                    out_last_next  = final_reg;
                    state_next     = ST_CHECK;
                end
            end
            ST_COMMIT:
            begin
                beat_time_next  = beat_time_reg + TIME_W'(span_reg);
                prev_next       = cur_reg;
                first_seen_next = 1'b1;
                if (last_reg)
                begin
                    beat_time_next  = '0;
                    next_time_next  = '0;
                    prev_next       = '0;
                    first_seen_next = 1'b0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            beat_time_reg  <= '0;
            next_time_reg  <= '0;
            prev_reg       <= '0;
            first_seen_reg <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            beat_time_reg  <= beat_time_next;
            next_time_reg  <= next_time_next;
            prev_reg       <= prev_next;
            first_seen_reg <= first_seen_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        span_reg      <= span_next;
        last_reg      <= last_next;
        prev_use_reg  <= prev_use_next;
        dt_reg        <= dt_next;
        prod_reg      <= prod_next;
        num_reg       <= num_next;
        final_reg     <= final_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign div_num      = num_reg;
    assign div_den      = span_reg;
    assign sample_valid = out_valid_reg;
    assign sample_value = out_value_reg;
    assign last_in_run  = out_last_reg;

    // The next sample never lies more than one period past the end of the beat in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> (dt_full <= TIME_W'(span_reg) + STEP_T))
        else $error("rrir_back: sample time ran ahead of beat time");

    // The divider is only busy or finishing while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (div_done || div_busy) |-> (state_reg == ST_WAIT))
        else $error("rrir_back: divider active outside the wait state");

    // The end of a record returns the timing state to reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT && last_reg)
        |=> (beat_time_reg == '0 && next_time_reg == '0 && !first_seen_reg))
        else $error("rrir_back: state not cleared at record end");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the RR interval uniform resampler.
// Predicts every resampled value from the accepted beats and checks the sample channel.
// Depends on rrir_pkg and rr_interval_uniform_resampler_top.
`timescale 1ns / 1ps

module testbench;
    import rrir_pkg::*;

    localparam int FRAC_BITS      = FRACTION_BITS_DEF;
    localparam int VALUE_LIMIT    = (1 << VALUE_W) - 1;
    localparam int DRAIN_CYCLES   = 200;
    localparam int PRESSURE_HOLD  = 2000;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               is_last;
    } sample_t;

    // Predicts the samples each beat produces and checks them in arrival order.
    class rr_sample_scoreboard;
        int unsigned         rate;
        logic [TIME_W-1:0]   beat_time;
        logic [TIME_W-1:0]   next_time;
        logic [INTERVAL_W-1:0] prev_interval;
        bit                  seen;
        sample_t             expected_samples[$];
        int                  mismatches;

        function new();
            rate = RATE_RESET;
            mismatches = 0;
            clear_record();
        endfunction

        function void clear_record();
            beat_time = '0;
            next_time = '0;
            prev_interval = '0;
            seen = 1'b0;
        endfunction

        // The register clamps written rates into 1..RATE_MAX.
        function void program_rate(logic [RATE_W-1:0] value);
            rate = value;
            if (rate == 0)
                rate = 1;
            if (rate > RATE_MAX)
                rate = RATE_MAX;
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        function void report(string msg);
            $display("[%0t] sample check: %s", $realtime, msg);
            mismatches++;
        endfunction

        // Predicts samples up to the new beat (a period short at a record end), at most MAX_RESULTS.
        function void note_beat(logic [INTERVAL_W-1:0] interval_ms, logic ends_record);
            longint unsigned     cur;
            longint unsigned     prev;
            longint unsigned     span;
            longint unsigned     dt;
            longint unsigned     num;
            longint unsigned     quot;
            logic [TIME_W-1:0]   gap_t;
            logic [VALUE_W-1:0]  values[$];
            sample_t             s;
            bit                  done;
            cur = interval_ms;
            if (cur == 0)
                cur = 1;
            prev = seen ? longint'(prev_interval) : cur;
            span = cur * rate;
            done = 1'b0;
            while (!done && values.size() < MAX_RESULTS)
            begin
                // Time differences wrap at the width of the time registers.
                gap_t = next_time - beat_time;
                dt = gap_t;
                if (dt > span || (ends_record && dt + SAMPLE_STEP > span))
                    done = 1'b1;
                else
                begin
                    num = prev * (span - dt) + cur * dt;
                    quot = (num << FRAC_BITS) / span;
                    if (quot > VALUE_LIMIT)
                        quot = VALUE_LIMIT;
                    values = {values, quot[VALUE_W-1:0]};
                    next_time = next_time + SAMPLE_STEP;
                end
            end
            foreach (values[i])
            begin
                s.value = values[i];
                s.is_last = (i == values.size() - 1);
                expected_samples = {expected_samples, s};
            end
            beat_time = beat_time + span[TIME_W-1:0];
            prev_interval = cur[INTERVAL_W-1:0];
            seen = 1'b1;
            if (ends_record)
                clear_record();
        endfunction

        function void check_sample(logic [VALUE_W-1:0] value, logic is_last);
            sample_t want;
            if (expected_samples.size() == 0)
            begin
                report($sformatf("unexpected sample %0d with nothing predicted", value));
                return;
            end
            want = expected_samples.pop_front();
            if (value !== want.value)
                report($sformatf("value got %0d, predicted %0d", value, want.value));
            if (is_last !== want.is_last)
                report($sformatf("last_in_run got %b, predicted %b", is_last, want.is_last));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [RATE_W-1:0]     cfg_wdata;
    logic                  beat_valid;
    logic                  beat_stall;
    logic [INTERVAL_W-1:0] rr_interval_ms;
    logic                  record_end;
    logic                  sample_valid;
    logic                  sample_stall;
    logic [VALUE_W-1:0]    sample_value;
    logic                  last_in_run;

    rr_sample_scoreboard sb;
    bit tx_idle;
    bit rx_idle;
    bit pressure_armed;
    bit pressure_done;
    int rx_hold;
    int rx_wait;

    rr_interval_uniform_resampler_top #(
        .FRACTION_BITS(FRAC_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .beat_valid    (beat_valid),
        .beat_stall    (beat_stall),
        .rr_interval_ms(rr_interval_ms),
        .record_end    (record_end),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .sample_value  (sample_value),
        .last_in_run   (last_in_run)
    );

    // Free-running 100 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Check every sample transaction against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && sample_valid === 1'b1 && sample_stall === 1'b0)
            sb.check_sample(sample_value, last_in_run);
    end

    // Sample receiver: random stall after each transaction, one long hold for back-pressure.
    initial
    begin
        sample_stall <= 1'b0;
        rx_idle = 1'b1;
        rx_hold = 0;
        rx_wait = 0;
        pressure_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                sample_stall <= 1'b1;
            end
            else
            begin
                if (sample_valid === 1'b1 && sample_stall === 1'b0)
                begin
                    if ($urandom_range(0, 39) == 0)
                        rx_idle = !rx_idle;
                    rx_wait = rx_idle ? $urandom_range(0, 11) : 0;
                    if (pressure_armed && !pressure_done)
                    begin
                        rx_hold = PRESSURE_HOLD;
                        pressure_done = 1'b1;
                    end
                end
                if (rx_hold > 0 || rx_wait > 0)
                begin
                    if (rx_wait > 0)
                        rx_wait--;
                    sample_stall <= 1'b1;
                end
                else
                    sample_stall <= 1'b0;
            end
        end
    end

    // Ends the run when no transaction moves on either channel for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((beat_valid === 1'b1 && beat_stall === 1'b0) ||
                (sample_valid === 1'b1 && sample_stall === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offers one beat, after a random gap when tx_idle is set, and returns at the edge that takes it.
    task automatic send_beat(input logic [INTERVAL_W-1:0] interval_ms, input logic ends_record);
        int gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            beat_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        beat_valid <= 1'b1;
        rr_interval_ms <= interval_ms;
        record_end <= ends_record;
        do
            @(posedge clk);
        while (beat_stall !== 1'b0);
        sb.note_beat(interval_ms, ends_record);
    endtask

    // Drains all predicted samples, then lets the back end finish beats that emit none.
    task automatic settle();
        beat_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        sb.program_rate(value);
        cfg_we <= 1'b0;
    endtask

    // Records of plausible heart rhythm, with some extreme and malformed beats mixed in.
    task automatic random_beats(input int count);
        int left_in_record;
        int pick;
        logic [INTERVAL_W-1:0] interval_ms;
        logic ends_record;
        left_in_record = $urandom_range(1, 12);
        repeat (count)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                interval_ms = $urandom_range(0, 4095);
            else if (pick == 1)
                interval_ms = $urandom_range(0, 15);
            else if (pick == 2)
                interval_ms = $urandom_range(3000, 4095);
            else
                interval_ms = $urandom_range(300, 1600);
            left_in_record--;
            ends_record = (left_in_record == 0) || ($urandom_range(0, 39) == 0);
            if (ends_record)
                left_in_record = $urandom_range(1, 12);
            send_beat(interval_ms, ends_record);
        end
    endtask

    // Main sequence: reset, directed beats, then random records under several rates.
    initial
    begin
        logic [RATE_W-1:0] rate_pick;
        sb = new();
        tx_idle = 1'b1;
        pressure_armed = 1'b0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        beat_valid <= 1'b0;
        rr_interval_ms <= '0;
        record_end <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset rate: samples before the first beat, zero interval, extremes, record ends.
        send_beat(12'd800, 1'b0);
        send_beat(12'd0, 1'b0);
        send_beat(12'd4095, 1'b0);
        send_beat(12'd1, 1'b0);
        send_beat(12'd2048, 1'b1);
        send_beat(12'd1000, 1'b1);
        send_beat(12'd0, 1'b1);
        settle();

        // A written rate of zero acts as the slowest rate.
        write_rate(4'd0);
        tx_idle = 1'b0;
        send_beat(12'd4095, 1'b0);
        send_beat(12'd4095, 1'b0);
        send_beat(12'd2730, 1'b0);
        send_beat(12'd1365, 1'b1);
        settle();

        // Rates above the maximum clamp; the longest beats give the most samples.
        write_rate(4'd15);
        tx_idle = 1'b1;
        send_beat(12'd4095, 1'b0);
        send_beat(12'd4095, 1'b0);
        send_beat(12'd600, 1'b0);
        send_beat(12'd4095, 1'b1);
        settle();

        // Rate change in the middle of a record.
        write_rate(4'd8);
        send_beat(12'd900, 1'b0);
        send_beat(12'd1100, 1'b0);
        settle();
        write_rate(4'd3);
        send_beat(12'd700, 1'b0);
        send_beat(12'd1200, 1'b1);
        settle();

        // Random records; the receiver holds off once early on to fill the block.
        write_rate(4'd9);
        pressure_armed = 1'b1;
        random_beats(22);
        for (int phase = 0; phase < 4; phase++)
        begin
            settle();
            rate_pick = (phase == 0) ? 4'd1 : (phase == 1) ? 4'd8 : 4'($urandom_range(0, 15));
            write_rate(rate_pick);
            tx_idle = $urandom_range(0, 1);
            random_beats(22);
        end
        settle();

        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
src/rrir_pkg.sv
src/rrir_front.sv
src/rrir_fifo.sv
src/rrir_div.sv
src/rrir_back.sv
src/rr_interval_uniform_resampler_top.sv
tb/testbench.sv
